// ===== rtl/bhpt_pkg.sv =====
`default_nettype none

package bhpt_pkg;

    // Block table: two sides of four entries, each an upper and a lower word.
    localparam int BAT_SIDE_ENTRIES = 4;
    localparam int BAT_CNT_W        = 2;
    localparam int BLK_DEPTH        = 16;
    localparam int SEG_DEPTH        = 16;
    localparam int SEG_W            = 24;
    localparam int SEEN_W           = 4;

    localparam int DEF_BLOCK_ENTRIES     = 4;
    localparam int DEF_ENTRIES_PER_GROUP = 8;

    localparam logic [31:0] BL_MASK   = 32'h0000_1FFC;
    localparam logic [31:0] HI_MASK   = 32'hFFFE_0000;
    localparam logic [31:0] LOW_KEEP  = 32'h0001_FFFF;

    typedef enum logic [1:0] {
        FN_XLATE  = 2'd0,
        FN_PTE    = 2'd1,
        FN_WR_BLK = 2'd2,
        FN_WR_SEG = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_XLATED = 2'd0,
        ST_FETCH  = 2'd1,
        ST_FAULT  = 2'd2
    } t_status;

    typedef struct packed {
        logic                 start;
        logic                 pte;
        logic                 wr_blk;
        logic                 wr_seg;
        logic                 walk;
        logic                 out_load;
        logic [BAT_CNT_W-1:0] ent;
    } t_cmd;

    typedef struct packed {
        logic bat_hit;
        logic pte_done;
        logic pending;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/bat_and_hashed_page_translate_unit.sv =====
// Channel   Direction  Handshake             Payload
// input     in         i_valid / o_stall     i_func, i_virt_address, i_user_mode,
//                                            i_instr_side, i_pte_word,
//                                            i_table_index, i_table_value
// result    out        o_valid / i_stall     o_status, o_phys_address, o_group_address
// config    in         i_cfg_wr_en           i_cfg_wr_data (table base / hash mask)
//
// A PTE word or table write is handled in the cycle of its transfer. A translate
// request walks the block entries of its side, one per cycle after its transfer,
// until a hit or the last of min(BLOCK_ENTRIES,4) entries; the group address is
// formed in the cycle of the last entry. One item is in work at a time; a new
// transfer is taken while the result register empties in the same cycle. Reset
// is synchronous, active low, and clears the block and segment tables, the
// table base and any pending search. A stalled result holds in the output
// register and holds off new input.

`default_nettype none

module bat_and_hashed_page_translate_unit
    import bhpt_pkg::*;
#(
    parameter int BLOCK_ENTRIES     = DEF_BLOCK_ENTRIES,
    parameter int ENTRIES_PER_GROUP = DEF_ENTRIES_PER_GROUP
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [31:0] i_virt_address,
    input  wire logic        i_user_mode,
    input  wire logic        i_instr_side,
    input  wire logic [63:0] i_pte_word,
    input  wire logic [3:0]  i_table_index,
    input  wire logic [31:0] i_table_value,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [31:0]      o_phys_address,
    output logic [31:0]      o_group_address,
    // configuration write
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data
);

    t_cmd cmd;
    t_sts sts;

    // Controller: sequence the block walk and own the handshakes.
    bhpt_ctrl #(
        .BLOCK_ENTRIES (BLOCK_ENTRIES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // Datapath: tables, block compare, hash, PTE search and result register.
    bhpt_dp #(
        .ENTRIES_PER_GROUP (ENTRIES_PER_GROUP)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_virt_address  (i_virt_address),
        .i_user_mode     (i_user_mode),
        .i_instr_side    (i_instr_side),
        .i_pte_word      (i_pte_word),
        .i_table_index   (i_table_index),
        .i_table_value   (i_table_value),
        .o_sts           (sts),
        .o_status        (o_status),
        .o_phys_address  (o_phys_address),
        .o_group_address (o_group_address)
    );

endmodule

`default_nettype wire

// ===== rtl/bhpt_ctrl.sv =====
`default_nettype none

module bhpt_ctrl
    import bhpt_pkg::*;
#(
    parameter int BLOCK_ENTRIES = DEF_BLOCK_ENTRIES
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_func,
    input  wire logic       i_stall,
    input  wire t_sts       i_sts,
    output logic            o_stall,
    output logic            o_valid,
    output t_cmd            o_cmd
);

    localparam int N_ENT = (BLOCK_ENTRIES > BAT_SIDE_ENTRIES) ? BAT_SIDE_ENTRIES
                                                              : BLOCK_ENTRIES;
    localparam logic [BAT_CNT_W-1:0] LAST_ENT = BAT_CNT_W'(N_ENT - 1);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state               r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    logic [BAT_CNT_W-1:0] r_cnt, n_cnt;
    logic                 in_ready;
    logic                 accept;

    assign in_ready = (r_state == S_IDLE) && (!r_out_valid || !i_stall);
    assign accept   = i_valid && in_ready;
    assign o_stall  = !in_ready;
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        o_cmd.ent   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_func'(i_func))
                        FN_XLATE: begin
                            o_cmd.start = 1'b1;
                            n_cnt       = '0;
                            n_state     = S_WALK;
                        end
                        FN_PTE: begin
                            o_cmd.pte = 1'b1;
                            if (i_sts.pending && i_sts.pte_done) begin
                                o_cmd.out_load = 1'b1;
                                n_out_valid    = 1'b1;
                            end
                        end
                        FN_WR_BLK: o_cmd.wr_blk = 1'b1;
                        FN_WR_SEG: o_cmd.wr_seg = 1'b1;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.bat_hit || r_cnt == LAST_ENT) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bhpt_dp.sv =====
`default_nettype none

module bhpt_dp
    import bhpt_pkg::*;
#(
    parameter int ENTRIES_PER_GROUP = DEF_ENTRIES_PER_GROUP
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire logic [31:0] i_virt_address,
    input  wire logic        i_user_mode,
    input  wire logic        i_instr_side,
    input  wire logic [63:0] i_pte_word,
    input  wire logic [3:0]  i_table_index,
    input  wire logic [31:0] i_table_value,
    output t_sts             o_sts,
    output logic [1:0]       o_status,
    output logic [31:0]      o_phys_address,
    output logic [31:0]      o_group_address
);

    localparam logic [SEEN_W-1:0] GROUP_LAST = SEEN_W'(ENTRIES_PER_GROUP);

    logic [31:0]       r_table_base;
    logic [31:0]       r_blk [BLK_DEPTH];
    logic [SEG_W-1:0]  r_seg [SEG_DEPTH];
    logic              r_pending;
    logic [31:0]       r_tag;
    logic [11:0]       r_offset;
    logic [SEEN_W-1:0] r_seen;
    logic [31:0]       r_va;
    logic              r_user;
    logic              r_side;
    t_status           r_status;
    logic [31:0]       r_phys;
    logic [31:0]       r_group;

    logic [31:0]       up_word, lo_word, bl, bat_mask, bat_pa;
    logic              vbit, bat_hit;
    logic [SEG_W-1:0]  vsid;
    logic [18:0]       hash;
    logic [31:0]       grp, tag;
    logic              pte_match, seen_last;
    logic [SEEN_W-1:0] seen_inc;

    // One block entry of the captured side per walk step.
    always_comb begin
        up_word  = r_blk[{r_side, i_cmd.ent, 1'b0}];
        lo_word  = r_blk[{r_side, i_cmd.ent, 1'b1}];
        vbit     = r_user ? up_word[0] : up_word[1];
        bl       = up_word & BL_MASK;
        bat_mask = ((~bl) << 15) & HI_MASK;
        bat_hit  = vbit && ((r_va & bat_mask) == (up_word & HI_MASK));
        bat_pa   = (lo_word & HI_MASK) | (r_va & ((bl << 15) | LOW_KEEP));
    end

    // Primary hash and group address.
    always_comb begin
        vsid = r_seg[r_va[31:28]];
        hash = vsid[18:0] ^ {3'b000, r_va[27:12]};
        grp  = {r_table_base[31:16] | {7'b0, r_table_base[8:0] & hash[18:10]},
                hash[9:0], 6'b0};
        tag  = {1'b1, vsid, 1'b0, r_va[27:22]};
    end

    assign pte_match = (i_pte_word[63:32] == r_tag);
    assign seen_inc  = r_seen + 1'b1;
    assign seen_last = (seen_inc >= GROUP_LAST);

    assign o_sts.bat_hit  = bat_hit;
    assign o_sts.pte_done = pte_match || seen_last;
    assign o_sts.pending  = r_pending;

    assign o_status        = r_status;
    assign o_phys_address  = r_phys;
    assign o_group_address = r_group;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_base <= '0;
            for (int k = 0; k < BLK_DEPTH; k++) r_blk[k] <= '0;
            for (int k = 0; k < SEG_DEPTH; k++) r_seg[k] <= '0;
            r_pending <= 1'b0;
            r_tag     <= '0;
            r_offset  <= '0;
            r_seen    <= '0;
        end else begin
            if (i_cfg_wr_en) r_table_base <= i_cfg_wr_data;
            if (i_cmd.wr_blk) r_blk[i_table_index] <= i_table_value;
            if (i_cmd.wr_seg) r_seg[i_table_index] <= i_table_value[SEG_W-1:0];
            // A new FN_XLATE request drops any search in flight.
            if (i_cmd.start) r_pending <= 1'b0;
            if (i_cmd.walk && i_cmd.out_load && !bat_hit) begin
                r_tag     <= tag;
                r_offset  <= r_va[11:0];
                r_seen    <= '0;
                r_pending <= 1'b1;
            end
            if (i_cmd.pte && r_pending) begin
                if (pte_match || seen_last) begin
                    r_pending <= 1'b0;
                    r_seen    <= '0;
                end else begin
                    r_seen <= seen_inc;
                end
            end
        end
    end

    // Request capture and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_va   <= i_virt_address;
            r_user <= i_user_mode;
            r_side <= i_instr_side;
        end
        if (i_cmd.out_load) begin
            if (i_cmd.walk) begin
                if (bat_hit) begin
                    r_status <= ST_XLATED;
                    r_phys   <= bat_pa;
                    r_group  <= '0;
                end else begin
                    r_status <= ST_FETCH;
                    r_phys   <= '0;
                    r_group  <= grp;
                end
            end else if (pte_match) begin
                r_status <= ST_XLATED;
                r_phys   <= {i_pte_word[31:12], r_offset};
                r_group  <= '0;
            end else begin
                r_status <= ST_FAULT;
                r_phys   <= '0;
                r_group  <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== dv/bhpt_tb_pkg.sv =====
`timescale 1ns / 1ps

package bhpt_tb_pkg;
    import bhpt_pkg::*;

    localparam logic [31:0] ORIGIN_MASK = 32'hFFFF_0000;
    localparam logic [31:0] HASH_MASK   = 32'h0000_01FF;
    localparam logic [31:0] HASH_LOW    = 32'h0000_03FF;
    localparam logic [31:0] VSID_HASH   = 32'h0007_FFFF;
    localparam logic [31:0] PTE_VALID   = 32'h8000_0000;
    localparam logic [31:0] PAGE_MASK   = 32'hFFFF_F000;
    localparam logic [31:0] USER_VALID  = 32'h0000_0001;
    localparam logic [31:0] SUPER_VALID = 32'h0000_0002;

    typedef struct packed {
        t_status     status;
        logic [31:0] phys;
        logic [31:0] group;
    } t_answer;

    class xlate_scoreboard;
        logic [31:0]      table_base;
        logic [31:0]      blk_tab [BLK_DEPTH];
        logic [SEG_W-1:0] seg_tab [SEG_DEPTH];
        bit               searching;
        logic [31:0]      tag;
        logic [11:0]      offset;
        int unsigned      seen;
        int unsigned      walk_len;
        int unsigned      group_len;
        t_answer          expected_answers[$];
        int unsigned      n_xlate, n_hit, n_fetch, n_pte_hit, n_fault, n_checked, n_errors;

        function new(int unsigned block_entries, int unsigned entries_per_group);
            walk_len  = (block_entries > BAT_SIDE_ENTRIES) ? BAT_SIDE_ENTRIES : block_entries;
            group_len = entries_per_group;
            table_base = '0;
            foreach (blk_tab[i]) blk_tab[i] = '0;
            foreach (seg_tab[i]) seg_tab[i] = '0;
            searching = 1'b0;
            tag       = '0;
            offset    = '0;
            seen      = 0;
        endfunction

        function void set_table_base(logic [31:0] value);
            table_base = value;
        endfunction

        // Advance the shadow state by one accepted transfer; queue its answer, if any.
        function void take_request(t_func fn, logic [31:0] va, logic usr, logic side,
                                   logic [63:0] pte, logic [3:0] idx, logic [31:0] val);
            logic [31:0] vbit, up, lo, bl, mask, vsid, hash;
            logic [3:0]  slot;
            bit          hit;
            t_answer     ans;
            ans = '0;
            case (fn)
                FN_WR_BLK: blk_tab[idx] = val;
                FN_WR_SEG: seg_tab[idx] = val[SEG_W-1:0];
                FN_XLATE: begin
                    n_xlate++;
                    searching = 1'b0;
                    hit  = 1'b0;
                    vbit = usr ? USER_VALID : SUPER_VALID;
                    for (int i = 0; i < walk_len && !hit; i++) begin
                        slot = {side, i[1:0], 1'b0};
                        up   = blk_tab[slot];
                        lo   = blk_tab[slot | 4'h1];
                        bl   = up & BL_MASK;
                        mask = (~bl << 15) & HI_MASK;
                        if ((up & vbit) != 0 && (va & mask) == (up & HI_MASK)) begin
                            hit        = 1'b1;
                            ans.status = ST_XLATED;
                            ans.phys   = (lo & HI_MASK) | (va & ((bl << 15) | LOW_KEEP));
                        end
                    end
                    if (hit) begin
                        n_hit++;
                    end else begin
                        vsid = 32'(seg_tab[va[31:28]]);
                        hash = (vsid & VSID_HASH) ^ {16'b0, va[27:12]};
                        ans.status = ST_FETCH;
                        ans.group  = (table_base & ORIGIN_MASK)
                                   | (((table_base & HASH_MASK) & (hash >> 10)) << 16)
                                   | ((hash & HASH_LOW) << 6);
                        tag       = (vsid << 7) | {26'b0, va[27:22]} | PTE_VALID;
                        offset    = va[11:0];
                        seen      = 0;
                        searching = 1'b1;
                        n_fetch++;
                    end
                    expected_answers.push_back(ans);
                end
                FN_PTE: begin
                    if (searching) begin
                        if (pte[63:32] == tag) begin
                            ans.status = ST_XLATED;
                            ans.phys   = (pte[31:0] & PAGE_MASK) | {20'b0, offset};
                            searching  = 1'b0;
                            seen       = 0;
                            n_pte_hit++;
                            expected_answers.push_back(ans);
                        end else begin
                            seen = (seen + 1) & 15;
                            if (seen >= group_len) begin
                                ans.status = ST_FAULT;
                                searching  = 1'b0;
                                seen       = 0;
                                n_fault++;
                                expected_answers.push_back(ans);
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            $display("mismatch in %s at result %0d: expected %08h, got %08h",
                     what, n_checked, want, got);
            n_errors++;
        endtask

        task check_answer(t_status st, logic [31:0] pa, logic [31:0] ga);
            t_answer want;
            n_checked++;
            if (expected_answers.size() == 0) begin
                report_mismatch("result with nothing outstanding", '0, {30'b0, st});
                return;
            end
            want = expected_answers.pop_front();
            if (st != want.status)
                report_mismatch("status", {30'b0, want.status}, {30'b0, st});
            if (pa != want.phys)
                report_mismatch("physical address", want.phys, pa);
            if (ga != want.group)
                report_mismatch("group address", want.group, ga);
        endtask
    endclass

endpackage

// ===== dv/bat_and_hashed_page_translate_unit_tb.sv =====
`timescale 1ns / 1ps

module bat_and_hashed_page_translate_unit_tb;
    import bhpt_pkg::*;
    import bhpt_tb_pkg::*;

    localparam int BLOCK_ENTRIES     = DEF_BLOCK_ENTRIES;
    localparam int ENTRIES_PER_GROUP = DEF_ENTRIES_PER_GROUP;
    localparam int PHASE_ITEMS       = 533;
    // Longest walk is four block entries plus the output register; leave margin.
    localparam int SETTLE_CYCLES     = 8;
    localparam int HOLD_CYCLES       = 300;
    localparam int LIMIT_CYCLES      = 400_000;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic [1:0]  i_func          = FN_XLATE;
    logic [31:0] i_virt_address  = '0;
    logic        i_user_mode     = 1'b0;
    logic        i_instr_side    = 1'b0;
    logic [63:0] i_pte_word      = '0;
    logic [3:0]  i_table_index   = '0;
    logic [31:0] i_table_value   = '0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_phys_address;
    logic [31:0] o_group_address;
    logic        i_cfg_wr_en     = 1'b0;
    logic [31:0] i_cfg_wr_data   = '0;

    // Idle percentages for each side, changed per phase by the stimulus.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // Long receiver hold: the stimulus bumps hold_reqs, the receiver counts it out.
    int unsigned hold_reqs = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;

    xlate_scoreboard sb = new(BLOCK_ENTRIES, ENTRIES_PER_GROUP);

    bat_and_hashed_page_translate_unit #(
        .BLOCK_ENTRIES     (BLOCK_ENTRIES),
        .ENTRIES_PER_GROUP (ENTRIES_PER_GROUP)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_virt_address  (i_virt_address),
        .i_user_mode     (i_user_mode),
        .i_instr_side    (i_instr_side),
        .i_pte_word      (i_pte_word),
        .i_table_index   (i_table_index),
        .i_table_value   (i_table_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_phys_address  (o_phys_address),
        .o_group_address (o_group_address),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.expected_answers.size());
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check the transfer that completed at this edge (pre-edge values),
    // then pick the stall for the next cycle. A long hold overrides random stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_answer(t_status'(o_status), o_phys_address, o_group_address);
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one item, idling first at random; hold the payload until the transfer.
    task automatic send_item(t_func fn, logic [31:0] va, logic usr, logic side,
                             logic [63:0] pte, logic [3:0] idx, logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= fn;
        i_virt_address <= va;
        i_user_mode    <= usr;
        i_instr_side   <= side;
        i_pte_word     <= pte;
        i_table_index  <= idx;
        i_table_value  <= val;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.take_request(fn, va, usr, side, pte, idx, val);
    endtask

    // Unused fields get random filler so every input bit toggles.
    task automatic send_xlate(logic [31:0] va, logic usr, logic side);
        send_item(FN_XLATE, va, usr, side, {$urandom, $urandom}, 4'($urandom), $urandom);
    endtask

    task automatic send_pte(logic [63:0] pte);
        send_item(FN_PTE, $urandom, 1'($urandom), 1'($urandom), pte, 4'($urandom), $urandom);
    endtask

    task automatic send_tbl_write(t_func fn, logic [3:0] idx, logic [31:0] val);
        send_item(fn, $urandom, 1'($urandom), 1'($urandom), {$urandom, $urandom}, idx, val);
    endtask

    // Block upper words get a contiguous length mask and mostly a valid bit set.
    function automatic logic [31:0] block_word(logic [3:0] idx);
        logic [31:0] w;
        int          k;
        w = $urandom;
        if (!idx[0]) begin
            k = $urandom_range(11);
            w[12:2] = 11'((1 << k) - 1);
            if (w[1:0] == 2'b00 && $urandom_range(3) != 0)
                w[1:0] = 2'($urandom_range(1, 3));
        end
        return w;
    endfunction

    task automatic send_random_write();
        logic [3:0] idx;
        idx = 4'($urandom);
        if ($urandom_range(1))
            send_tbl_write(FN_WR_BLK, idx, block_word(idx));
        else
            send_tbl_write(FN_WR_SEG, idx, $urandom);
    endtask

    // Aim an address at a block entry of the given side so the walk can hit.
    function automatic logic [31:0] block_target(logic side);
        logic [31:0] up, span;
        up   = sb.blk_tab[{side, 2'($urandom_range(3)), 1'b0}];
        span = {4'b0, up[12:2], 17'b0};
        return (up & HI_MASK & ~span) | ($urandom & (span | LOW_KEEP));
    endfunction

    function automatic logic [63:0] miss_word();
        if ($urandom_range(1))
            return {sb.tag ^ (32'h1 << $urandom_range(31)), 32'($urandom)};
        return {32'($urandom), 32'($urandom)};
    endfunction

    // Drop valid, drain every outstanding result, then let a silent item finish.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.expected_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_table_base(logic [31:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        sb.set_table_base(value);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= $urandom;
    endtask

    // Mostly well-formed searches: a translate, then a run of PTE words that may
    // contain the match; sprinkle table writes and stray items as noise.
    task automatic run_random(int unsigned quota);
        int unsigned done;
        int unsigned roll, n_words, hit_at;
        logic        side;
        logic [31:0] va;
        done = 0;
        while (done < quota) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                send_random_write();
                done++;
            end else if (roll < 13) begin
                send_item(t_func'($urandom_range(3)), $urandom, 1'($urandom), 1'($urandom),
                          {$urandom, $urandom}, 4'($urandom), $urandom);
                done++;
            end else begin
                side = 1'($urandom);
                va   = ($urandom_range(99) < 35) ? block_target(side) : 32'($urandom);
                send_xlate(va, 1'($urandom), side);
                done++;
                if (sb.searching) begin
                    n_words = $urandom_range(1, ENTRIES_PER_GROUP + 1);
                    hit_at  = ($urandom_range(99) < 60) ? $urandom_range(n_words - 1) : n_words;
                    for (int k = 0; k < n_words; k++) begin
                        if ($urandom_range(99) < 5) begin
                            send_random_write();
                            done++;
                        end
                        done++;
                        send_pte((k == hit_at) ? {sb.tag, 32'($urandom)} : miss_word());
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset tables and table base, then the corner cases.
        send_xlate(32'h0000_0000, 1'b0, 1'b0);
        send_pte({sb.tag, 32'hFFFF_FFFF});
        // no search outstanding: dropped silently
        send_pte(64'hFFFF_FFFF_FFFF_FFFF);

        write_table_base(32'hFFFF_FFFF);
        // segment table keeps only the low 24 bits
        send_tbl_write(FN_WR_SEG, 4'hF, 32'hFFFF_FFFF);
        send_xlate(32'hFFFF_FFFF, 1'b1, 1'b1);
        // a full group of misses ends in a fault on the last word
        for (int k = 0; k < ENTRIES_PER_GROUP; k++)
            send_pte(k[0] ? {~sb.tag, 32'hFFFF_FFFF} : 64'h0);

        // a table write leaves the captured tag alone; a new translate restarts
        send_xlate(32'h0ABC_DEF0, 1'b0, 1'b0);
        send_tbl_write(FN_WR_SEG, 4'h0, 32'h00A5_5A5A);
        send_xlate(32'h0123_4567, 1'b1, 1'b0);
        send_pte({sb.tag, 32'h0000_0000});

        // instruction side, last entry, widest block: hit after three invalid entries
        send_tbl_write(FN_WR_BLK, 4'hE, 32'hF000_1FFF);
        send_tbl_write(FN_WR_BLK, 4'hF, 32'hFFFF_FFFF);
        send_xlate(32'hFFFF_FFFF, 1'b1, 1'b1);

        // data side entry valid for supervisor only: user misses, supervisor hits
        send_tbl_write(FN_WR_BLK, 4'h0, 32'h0000_0002);
        send_tbl_write(FN_WR_BLK, 4'h1, 32'hABCD_E000);
        send_xlate(32'h0001_FFFF, 1'b1, 1'b0);
        send_xlate(32'h0001_FFFF, 1'b0, 1'b0);

        // Random phases, each under its own table base and idling pattern.
        send_idle_pct = 29;
        recv_idle_pct = 87;
        write_table_base(32'h0000_0000);
        run_random(PHASE_ITEMS);

        send_idle_pct = 87;
        recv_idle_pct = 29;
        write_table_base($urandom);
        run_random(PHASE_ITEMS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_table_base(32'hFFFF_01FF);
        run_random(PHASE_ITEMS / 4);
        // hold the result side while items keep coming, so the input backs up
        hold_reqs++;
        run_random(PHASE_ITEMS - PHASE_ITEMS / 4);

        wait_idle();
        $display("covered %0d translates: %0d block hits, %0d group fetches,",
                 sb.n_xlate, sb.n_hit, sb.n_fetch);
        $display("%0d PTE hits, %0d faults, %0d results checked over four table base values",
                 sb.n_pte_hit, sb.n_fault, sb.n_checked);
        if (sb.n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
